// ===== rtl/core/tts_pkg.sv =====
// shared types, constants and saturation helper for the three-band tone shaper
`timescale 1ns / 1ps
`default_nettype none

package tts_pkg;

  // internal signal and state width (signed)
  localparam int DATA_W    = 32;
  // shared multiplier operand widths and product width
  localparam int COEF_OP_W = 32;
  localparam int DATA_OP_W = 34;
  localparam int PROD_W    = COEF_OP_W + DATA_OP_W;
  // working width for rounding, accumulation and saturation
  localparam int ACC_W     = 72;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;
  localparam int UCOEF_W    = 23;
  localparam int SCOEF_W    = 25;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LP_STEP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BP_GAIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BP_FEEDBACK = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HP_POLE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_TARGET  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BELL_TARGET = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_TARGET = 3'd7;

  // multiply steps of one item, in execution order
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_LP_UPDATE = 3'd0;
  localparam logic [STEP_W-1:0] STEP_LOW_MIX   = 3'd1;
  localparam logic [STEP_W-1:0] STEP_BP_A1     = 3'd2;
  localparam logic [STEP_W-1:0] STEP_BP_A2     = 3'd3;
  localparam logic [STEP_W-1:0] STEP_BP_B0     = 3'd4;
  localparam logic [STEP_W-1:0] STEP_BELL_MIX  = 3'd5;
  localparam logic [STEP_W-1:0] STEP_HP_UPDATE = 3'd6;
  localparam logic [STEP_W-1:0] STEP_HIGH_MIX  = 3'd7;
  localparam logic [STEP_W-1:0] STEP_LAST      = STEP_HIGH_MIX;

  // saturation bounds for the internal word
  localparam logic signed [ACC_W-1:0] SAT_HI =
    {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO =
    {{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

  // commands from controller to datapath
  typedef struct packed {
    logic              capture;
    logic              mul;
    logic              wb;
    logic              emit;
    logic [STEP_W-1:0] step;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic enabled;
  } status_t;

  // clamp a working value to the signed internal word
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[DATA_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[DATA_W-1:0];
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tts_ctrl.sv =====
// controller state machine: sequences capture, eight multiply steps for enabled items, and output
`timescale 1ns / 1ps
`default_nettype none

module tts_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  input  wire tts_pkg::status_t status_i,
  output tts_pkg::cmd_t        cmd_o
);
  import tts_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_WB   = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;

  // next state and commands
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    cmd_o       = '0;
    cmd_o.step  = step_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          step_d        = STEP_LP_UPDATE;
          state_d       = status_i.enabled ? ST_MUL : ST_DONE;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_WB;
      end
      ST_WB: begin
        cmd_o.wb = 1'b1;
        if (step_q == STEP_LAST) begin
          state_d = ST_DONE;
        end else begin
          step_d  = step_q + 3'd1;
          state_d = ST_MUL;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output item valid: set on emit, cleared when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= STEP_LP_UPDATE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/core/tts_datapath.sv =====
// datapath: config registers, filter state, gain smoothers and one shared multiplier
`timescale 1ns / 1ps
`default_nettype none

module tts_datapath #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int COEF_FRAC    = 22,
  parameter int SMOOTH_SHIFT = 8
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [tts_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [tts_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0]       sample_in_i,
  input  wire logic                                 block_end_i,
  input  wire tts_pkg::cmd_t                        cmd_i,
  output tts_pkg::status_t                          status_o,
  output logic signed [SAMPLE_WIDTH-1:0]            sample_out_o,
  output logic                                      block_end_out_o
);
  import tts_pkg::*;

  // sample format rescale between Q1.(SAMPLE_WIDTH-1) and COEF_FRAC fraction bits
  localparam int RESCALE = SAMPLE_WIDTH - 1 - COEF_FRAC;
  localparam int RSH     = (RESCALE >= 0) ? RESCALE : 0;
  localparam int LSH     = (RESCALE < 0) ? -RESCALE : 0;
  localparam logic signed [ACC_W-1:0] RND_COEF = ACC_W'(1) <<< (COEF_FRAC - 1);
  localparam logic signed [ACC_W-1:0] RND_OUT  =
    (LSH > 0) ? (ACC_W'(1) <<< (LSH - 1)) : '0;
  localparam logic signed [ACC_W-1:0] OUT_HI =
    {{(ACC_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] OUT_LO =
    {{(ACC_W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] UNITY = DATA_W'(1) <<< COEF_FRAC;

  // configuration registers
  logic                       enabled_q;
  logic [UCOEF_W-1:0]         lp_step_q;
  logic signed [SCOEF_W-1:0]  bp_gain_q;
  logic signed [SCOEF_W-1:0]  bp_fb_q;
  logic [UCOEF_W-1:0]         hp_pole_q;
  logic signed [SCOEF_W-1:0]  low_tgt_q;
  logic signed [SCOEF_W-1:0]  bell_tgt_q;
  logic signed [SCOEF_W-1:0]  high_tgt_q;

  // filter state and smoothed gains
  logic signed [DATA_W-1:0] lp_q, d1_q, d2_q, hp_q, prev_q;
  logic signed [DATA_W-1:0] k_low_q, k_bell_q, k_high_q;

  // per-item working registers
  logic signed [SAMPLE_WIDTH-1:0] s_q;
  logic                           be_q;
  logic                           byp_q;
  logic signed [DATA_W-1:0]       x_q, w_q, c_q, tmp_q;
  logic signed [PROD_W-1:0]       acc_q, prod_q;

  logic signed [COEF_OP_W-1:0]    coef_op;
  logic signed [DATA_OP_W-1:0]    data_op;
  logic signed [PROD_W-1:0]       prod_d;
  logic signed [DATA_W-1:0]       a2;
  logic signed [ACC_W-1:0]        rs_val;
  logic signed [ACC_W-1:0]        sx;
  logic signed [DATA_W-1:0]       x_d;
  logic signed [DATA_W-1:0]       res_d;

  // one-pole gain smoother with a shift and a unit nudge upward
  function automatic logic signed [DATA_W-1:0] glide(
    input logic signed [DATA_W-1:0]  now,
    input logic signed [SCOEF_W-1:0] tgt
  );
    logic signed [DATA_OP_W-1:0] diff;
    logic signed [DATA_OP_W-1:0] stp;
    diff = DATA_OP_W'(tgt) - DATA_OP_W'(now);
    stp  = diff >>> SMOOTH_SHIFT;
    if ((stp == '0) && (diff > 0)) begin
      stp = DATA_OP_W'(1);
    end
    return sat32(ACC_W'(now) + ACC_W'(stp));
  endfunction

  // convert the internal word back to the sample format, saturated
  function automatic logic signed [SAMPLE_WIDTH-1:0] to_sample(
    input logic signed [DATA_W-1:0] y
  );
    logic signed [ACC_W-1:0] r;
    logic signed [SAMPLE_WIDTH-1:0] o;
    if (RESCALE >= 0) begin
      r = ACC_W'(y) <<< RSH;
    end else begin
      r = (ACC_W'(y) + RND_OUT) >>> LSH;
    end
    if (r > OUT_HI) begin
      o = OUT_HI[SAMPLE_WIDTH-1:0];
    end else if (r < OUT_LO) begin
      o = OUT_LO[SAMPLE_WIDTH-1:0];
    end else begin
      o = r[SAMPLE_WIDTH-1:0];
    end
    return o;
  endfunction

  assign status_o.enabled = enabled_q;

  // input rescale to internal fraction bits (floor when bits drop)
  assign sx  = ACC_W'(sample_in_i);
  assign x_d = (RESCALE >= 0) ? DATA_W'(sx >>> RSH) : DATA_W'(sx <<< LSH);

  // second bandpass feedback coefficient: one minus twice b0
  assign a2 = UNITY - (DATA_W'(bp_gain_q) <<< 1);

  // operand select for the shared multiplier
  always_comb begin
    coef_op = '0;
    data_op = '0;
    case (cmd_i.step)
      STEP_LP_UPDATE: begin
        coef_op = $signed({{(COEF_OP_W-UCOEF_W){1'b0}}, lp_step_q});
        data_op = DATA_OP_W'(x_q) - DATA_OP_W'(lp_q);
      end
      STEP_LOW_MIX: begin
        coef_op = k_low_q;
        data_op = DATA_OP_W'(lp_q);
      end
      STEP_BP_A1: begin
        coef_op = COEF_OP_W'(bp_fb_q);
        data_op = DATA_OP_W'(d1_q);
      end
      STEP_BP_A2: begin
        coef_op = a2;
        data_op = DATA_OP_W'(d2_q);
      end
      STEP_BP_B0: begin
        coef_op = COEF_OP_W'(bp_gain_q);
        data_op = DATA_OP_W'(tmp_q) - DATA_OP_W'(d2_q);
      end
      STEP_BELL_MIX: begin
        coef_op = k_bell_q;
        data_op = DATA_OP_W'(tmp_q);
      end
      STEP_HP_UPDATE: begin
        coef_op = $signed({{(COEF_OP_W-UCOEF_W){1'b0}}, hp_pole_q});
        data_op = DATA_OP_W'(hp_q) + DATA_OP_W'(c_q) - DATA_OP_W'(prev_q);
      end
      STEP_HIGH_MIX: begin
        coef_op = k_high_q;
        data_op = DATA_OP_W'(hp_q);
      end
      default: begin
        coef_op = '0;
        data_op = '0;
      end
    endcase
  end

  assign prod_d = PROD_W'(coef_op) * PROD_W'(data_op);

  // round the registered product (with the a1 term on the second feedback step)
  assign rs_val = (ACC_W'(prod_q)
                   + ((cmd_i.step == STEP_BP_A2) ? ACC_W'(acc_q) : ACC_W'(0))
                   + RND_COEF) >>> COEF_FRAC;

  // write-back result per step
  always_comb begin
    case (cmd_i.step)
      STEP_LP_UPDATE: res_d = sat32(ACC_W'(lp_q) + rs_val);
      STEP_LOW_MIX:   res_d = sat32(ACC_W'(x_q) + rs_val);
      STEP_BP_A2:     res_d = sat32(ACC_W'(w_q) - rs_val);
      STEP_BELL_MIX:  res_d = sat32(ACC_W'(w_q) + rs_val);
      STEP_HIGH_MIX:  res_d = sat32(ACC_W'(c_q) + rs_val);
      default:        res_d = sat32(rs_val);
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q  <= 1'b1;
      lp_step_q  <= '0;
      bp_gain_q  <= '0;
      bp_fb_q    <= '0;
      hp_pole_q  <= '0;
      low_tgt_q  <= '0;
      bell_tgt_q <= '0;
      high_tgt_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ENABLED:     enabled_q  <= cfg_data_i[0];
        CFG_LP_STEP:     lp_step_q  <= cfg_data_i[UCOEF_W-1:0];
        CFG_BP_GAIN:     bp_gain_q  <= $signed(cfg_data_i[SCOEF_W-1:0]);
        CFG_BP_FEEDBACK: bp_fb_q    <= $signed(cfg_data_i[SCOEF_W-1:0]);
        CFG_HP_POLE:     hp_pole_q  <= cfg_data_i[UCOEF_W-1:0];
        CFG_LOW_TARGET:  low_tgt_q  <= $signed(cfg_data_i[SCOEF_W-1:0]);
        CFG_BELL_TARGET: bell_tgt_q <= $signed(cfg_data_i[SCOEF_W-1:0]);
        CFG_HIGH_TARGET: high_tgt_q <= $signed(cfg_data_i[SCOEF_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  // filter state and gains, updated only for shaped items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lp_q     <= '0;
      d1_q     <= '0;
      d2_q     <= '0;
      hp_q     <= '0;
      prev_q   <= '0;
      k_low_q  <= '0;
      k_bell_q <= '0;
      k_high_q <= '0;
    end else begin
      if (cmd_i.capture && enabled_q) begin
        k_low_q  <= glide(k_low_q, low_tgt_q);
        k_bell_q <= glide(k_bell_q, bell_tgt_q);
        k_high_q <= glide(k_high_q, high_tgt_q);
      end
      if (cmd_i.wb) begin
        case (cmd_i.step)
          STEP_LP_UPDATE: lp_q <= res_d;
          STEP_BP_B0: begin
            d2_q <= d1_q;
            d1_q <= tmp_q;
          end
          STEP_HP_UPDATE: begin
            hp_q   <= res_d;
            prev_q <= c_q;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // per-item working registers and multiplier pipeline register
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      s_q   <= sample_in_i;
      be_q  <= block_end_i;
      byp_q <= !enabled_q;
      x_q   <= x_d;
    end
    if (cmd_i.mul) begin
      prod_q <= prod_d;
    end
    if (cmd_i.wb) begin
      case (cmd_i.step)
        STEP_LOW_MIX:  w_q   <= res_d;
        STEP_BP_A1:    acc_q <= prod_q;
        STEP_BP_A2:    tmp_q <= res_d;
        STEP_BP_B0:    tmp_q <= res_d;
        STEP_BELL_MIX: c_q   <= res_d;
        STEP_HIGH_MIX: tmp_q <= res_d;
        default: begin
        end
      endcase
    end
    if (cmd_i.emit) begin
      sample_out_o    <= byp_q ? s_q : to_sample(tmp_q);
      block_end_out_o <= be_q;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/three_band_tone_shaper.sv =====
// three-band tone shaper: one output sample per input item
// shaped item: eight steps of one shared multiplier, each a multiply
//   state and a write-back state, then a done state registers the result
// pass-through item (enabled = 0): skips the steps, straight to the done state
// input stalls until the result is emitted; emit waits on a stalled output
// reset: filter state and gains zero, enabled = 1, other config registers zero
`timescale 1ns / 1ps
`default_nettype none

module three_band_tone_shaper #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int COEF_FRAC    = 22,
  parameter int SMOOTH_SHIFT = 8
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [tts_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [tts_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic signed [SAMPLE_WIDTH-1:0]    sample_in_i,
  input  wire logic                              block_end_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0]         sample_out_o,
  output logic                                   block_end_out_o
);
  import tts_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer
  tts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // arithmetic and state
  tts_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_FRAC    (COEF_FRAC),
    .SMOOTH_SHIFT (SMOOTH_SHIFT)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .sample_in_i     (sample_in_i),
    .block_end_i     (block_end_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .sample_out_o    (sample_out_o),
    .block_end_out_o (block_end_out_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/tts_checker.sv =====
// port-level checker for the three-band tone shaper and its bind
`timescale 1ns / 1ps
`default_nettype none

module tts_checker #(
  parameter int SAMPLE_WIDTH = 24
) (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_valid_i,
  input wire logic                           in_stall_o,
  input wire logic                           out_valid_o,
  input wire logic                           out_stall_i,
  input wire logic signed [SAMPLE_WIDTH-1:0] sample_out_o,
  input wire logic                           block_end_out_o
);

  // a stalled output item stays valid
  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output item dropped while stalled");

  // a stalled output item keeps its payload
  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(sample_out_o) && $stable(block_end_out_o))
    else $error("output payload changed while stalled");

  // one item at a time: input is stalled right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item accepted while one is in work");

  // a new output item only appears at the end of an item's work
  a_out_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("output item without work in progress");

endmodule

bind three_band_tone_shaper tts_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_tts_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .sample_out_o    (sample_out_o),
  .block_end_out_o (block_end_out_o)
);

`default_nettype wire
